[hdl/avkf_pkg.sv]
// Shared types, constants and saturating fixed-point helpers for the altitude/velocity filter.
// Used by avkf_mul, avkf_div and the altitude_velocity_kalman_filter top level.
package avkf_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned MAG_W      = 2 * DATA_WIDTH;

   // Multiplier: one 4-bit digit of the multiplier per cycle.
   localparam int unsigned MUL_DIGIT  = 4;
   localparam int unsigned MUL_STEPS  = DATA_WIDTH / MUL_DIGIT;
   localparam int unsigned MUL_CNT_W  = $clog2(MUL_STEPS);

   // Divider: one quotient bit per cycle over the scaled dividend.
   localparam int unsigned DIV_NUM_W  = DATA_WIDTH + FRAC_BITS;
   localparam int unsigned DIV_STEPS  = DIV_NUM_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int unsigned STEP_TIME_W = 17;
   localparam int unsigned NOISE_W     = 31;

   // Register index on the configuration port (byte address divided by 4).
   typedef enum logic [1:0] {
      REG_STEP_TIME,
      REG_PROCESS_NOISE,
      REG_MEASUREMENT_NOISE,
      REG_SPARE              // no register at this index
   } reg_index_type;

   localparam logic [STEP_TIME_W-1:0] STEP_TIME_RESET         = 17'd328;
   localparam logic [NOISE_W-1:0]     PROCESS_NOISE_RESET     = 31'd6554;
   localparam logic [NOISE_W-1:0]     MEASUREMENT_NOISE_RESET = 31'd655360;

   localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] FIX_ONE  = DATA_WIDTH'(1) << FRAC_BITS;

   localparam logic [MAG_W-1:0] MAG_ONE     = MAG_W'(1);
   localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_ONE << (DATA_WIDTH - 1);
   localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_NEG_LIM - MAG_ONE;

   typedef struct packed {
      logic                         start;
      logic signed [DATA_WIDTH-1:0] a;
      logic signed [DATA_WIDTH-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [DATA_WIDTH-1:0] value;
   } mul_rsp_type;

   typedef struct packed {
      logic                         start;
      logic signed [DATA_WIDTH-1:0] num_a;
      logic signed [DATA_WIDTH-1:0] num_b;
      logic signed [DATA_WIDTH-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [DATA_WIDTH-1:0] quo_a;
      logic signed [DATA_WIDTH-1:0] quo_b;
   } div_rsp_type;

   // Absolute value; the most negative value maps to 2^(DATA_WIDTH-1).
   function automatic logic [DATA_WIDTH-1:0] magnitude(input logic signed [DATA_WIDTH-1:0] x);
      logic [DATA_WIDTH-1:0] m;
      m = x[DATA_WIDTH-1] ? (~x + DATA_WIDTH'(1)) : x;
      return m;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_add(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b
   );
      logic [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end
      return s[DATA_WIDTH-1:0];
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b
   );
      logic [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end
      return s[DATA_WIDTH-1:0];
   endfunction

   // Sign and magnitude to a saturated two's complement value.
   function automatic logic signed [DATA_WIDTH-1:0] sat_from_mag(
      input logic             neg,
      input logic [MAG_W-1:0] mag
   );
      logic [DATA_WIDTH-1:0] low;
      low = mag[DATA_WIDTH-1:0];
      if (neg) begin
         if (mag > MAG_NEG_LIM) begin
            return DATA_MIN;
         end
         return ~low + DATA_WIDTH'(1);
      end
      if (mag > MAG_POS_LIM) begin
         return DATA_MAX;
      end
      return low;
   endfunction

endpackage

[hdl/avkf_mul.sv]
// Digit-serial fixed-point multiplier: 4 multiplier bits per cycle, floor rounding, saturation.
// Depends on avkf_pkg.
module avkf_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  avkf_pkg::mul_req_type mul_req,
   output avkf_pkg::mul_rsp_type mul_rsp
);

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_RUN,
      MUL_FIN
   } mul_state_type;

   localparam int unsigned W = avkf_pkg::DATA_WIDTH;
   localparam int unsigned D = avkf_pkg::MUL_DIGIT;

   mul_state_type                       state_ff, state_in;
   logic [avkf_pkg::MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [W-1:0]                        mag_a_ff, mag_a_in;
   logic [2*W-1:0]                      prod_ff, prod_in;
   logic                                neg_ff, neg_in;
   logic                                done_ff, done_in;
   logic signed [W-1:0]                 value_ff, value_in;
   logic [W+D-1:0]                      sum;
   logic [2*W-1:0]                      shifted;

   always_comb begin
      sum = {{D{1'b0}}, prod_ff[2*W-1:W]}
          + ({{D{1'b0}}, mag_a_ff} * {{W{1'b0}}, prod_ff[D-1:0]});
      shifted = prod_ff >> avkf_pkg::FRAC_BITS;
      if (neg_ff && (prod_ff[avkf_pkg::FRAC_BITS-1:0] != '0)) begin
         shifted = shifted + (2*W)'(1);
      end

      state_in = state_ff;
      cnt_in   = cnt_ff;
      mag_a_in = mag_a_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      value_in = value_ff;

      case (state_ff)
         MUL_IDLE: begin
            if (mul_req.start) begin
               mag_a_in = avkf_pkg::magnitude(mul_req.a);
               prod_in  = {{W{1'b0}}, avkf_pkg::magnitude(mul_req.b)};
               neg_in   = mul_req.a[W-1] ^ mul_req.b[W-1];
               cnt_in   = '0;
               state_in = MUL_RUN;
            end
         end
         MUL_RUN: begin
            // shift in the new partial sum, drop the consumed digit
            prod_in = {sum, prod_ff[W-1:D]};
            cnt_in  = cnt_ff + avkf_pkg::MUL_CNT_W'(1);
            if (cnt_ff == avkf_pkg::MUL_CNT_W'(avkf_pkg::MUL_STEPS - 1)) begin
               state_in = MUL_FIN;
            end
         end
         MUL_FIN: begin
            value_in = avkf_pkg::sat_from_mag(neg_ff, avkf_pkg::MAG_W'(shifted));
            done_in  = 1'b1;
            state_in = MUL_IDLE;
         end
         default: begin
            state_in = MUL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      mag_a_ff <= mag_a_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      value_ff <= value_in;
   end

   assign mul_rsp.done  = done_ff;
   assign mul_rsp.value = value_ff;

endmodule

[hdl/avkf_div.sv]
// Bit-serial restoring divider: two numerators over one shared denominator, one bit per cycle.
// Depends on avkf_pkg.
module avkf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  avkf_pkg::div_req_type div_req,
   output avkf_pkg::div_rsp_type div_rsp
);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_FIN
   } div_state_type;

   localparam int unsigned W = avkf_pkg::DATA_WIDTH;
   localparam int unsigned N = avkf_pkg::DIV_NUM_W;

   div_state_type                  state_ff, state_in;
   logic [avkf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]                   dsr_ff, dsr_in;
   logic                           zero_ff, zero_in;
   logic [1:0]                     neg_ff, neg_in;
   logic [N-1:0]                   dvd_ff [2];
   logic [N-1:0]                   dvd_in [2];
   logic [W-1:0]                   rem_ff [2];
   logic [W-1:0]                   rem_in [2];
   logic                           done_ff, done_in;
   logic signed [W-1:0]            quo_ff [2];
   logic signed [W-1:0]            quo_in [2];
   logic [W:0]                     trial [2];
   logic [W:0]                     diff  [2];
   logic                           fits  [2];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dsr_in   = dsr_ff;
      zero_in  = zero_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      for (int i = 0; i < 2; i++) begin
         dvd_in[i] = dvd_ff[i];
         rem_in[i] = rem_ff[i];
         quo_in[i] = quo_ff[i];
         trial[i]  = {rem_ff[i], dvd_ff[i][N-1]};
         diff[i]   = trial[i] - {1'b0, dsr_ff};
         fits[i]   = trial[i] >= {1'b0, dsr_ff};
      end

      case (state_ff)
         DIV_IDLE: begin
            if (div_req.start) begin
               dsr_in    = avkf_pkg::magnitude(div_req.den);
               zero_in   = (div_req.den == '0);
               neg_in[0] = div_req.num_a[W-1] ^ div_req.den[W-1];
               neg_in[1] = div_req.num_b[W-1] ^ div_req.den[W-1];
               dvd_in[0] = {avkf_pkg::magnitude(div_req.num_a), {avkf_pkg::FRAC_BITS{1'b0}}};
               dvd_in[1] = {avkf_pkg::magnitude(div_req.num_b), {avkf_pkg::FRAC_BITS{1'b0}}};
               rem_in[0] = '0;
               rem_in[1] = '0;
               cnt_in    = '0;
               state_in  = DIV_RUN;
            end
         end
         DIV_RUN: begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            for (int i = 0; i < 2; i++) begin
               rem_in[i] = fits[i] ? diff[i][W-1:0] : trial[i][W-1:0];
               dvd_in[i] = {dvd_ff[i][N-2:0], fits[i]};
            end
            cnt_in = cnt_ff + avkf_pkg::DIV_CNT_W'(1);
            if (cnt_ff == avkf_pkg::DIV_CNT_W'(avkf_pkg::DIV_STEPS - 1)) begin
               state_in = DIV_FIN;
            end
         end
         DIV_FIN: begin
            for (int i = 0; i < 2; i++) begin
               quo_in[i] = zero_ff ? '0
                         : avkf_pkg::sat_from_mag(neg_ff[i], avkf_pkg::MAG_W'(dvd_ff[i]));
            end
            done_in  = 1'b1;
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      dsr_ff  <= dsr_in;
      zero_ff <= zero_in;
      neg_ff  <= neg_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.quo_a = quo_ff[0];
   assign div_rsp.quo_b = quo_ff[1];

endmodule

[hdl/altitude_velocity_kalman_filter.sv]
// Top level of the two-state altitude/velocity Kalman filter: sequencer, state and CSRs.
// Depends on avkf_pkg, avkf_mul and avkf_div.
//
//   port group  dir  width      transfers
//   req_        in   32         measured_height (Q16.16 m), one per filter step
//   rsp_        out  64         height_out [31:0], velocity_out [63:32], one per step
//   csr_        -    32 / 4     step_time @0x0, process_noise @0x4, measurement_noise @0x8
//
// Each item passes through eleven multiplies on the shared 4-bit digit-serial multiplier and
// one bit-serial division pass that yields both gains together; the next item is taken
// only after the sequencer has returned to idle.
// Reset is synchronous; estimates clear to zero and the covariance returns to identity.
// A finished result waits in the rsp_ output register; the next item is taken while it
// waits, and the sequencer holds in its last step only if a second result is ready first.
module altitude_velocity_kalman_filter (
   input  logic                   clock,
   input  logic                   reset,
   // slave side
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,    // [31:0] measured_height
   // master side
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,    // [31:0] height_out, [63:32] velocity_out
   // configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int unsigned W = avkf_pkg::DATA_WIDTH;

   // One state per multiply, named after its operands.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_M_VDT,
      ST_M_HVDT,
      ST_M_VHDT,
      ST_M_VVDT,
      ST_M_CDT,
      ST_DEN,
      ST_DIV,
      ST_M_K1E,
      ST_M_K2E,
      ST_M_P1OMK,
      ST_M_P2OMK,
      ST_M_K2P1,
      ST_M_K2P2,
      ST_OUT
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // configuration registers
   logic [avkf_pkg::STEP_TIME_W-1:0] step_time_ff, step_time_in;
   logic [avkf_pkg::NOISE_W-1:0]     proc_noise_ff, proc_noise_in;
   logic [avkf_pkg::NOISE_W-1:0]     meas_noise_ff, meas_noise_in;

   // filter state
   logic signed [W-1:0] h_ff, h_in;
   logic signed [W-1:0] v_ff, v_in;
   logic signed [W-1:0] phh_ff, phh_in;
   logic signed [W-1:0] phv_ff, phv_in;
   logic signed [W-1:0] pvh_ff, pvh_in;
   logic signed [W-1:0] pvv_ff, pvv_in;

   // per-step working values
   logic signed [W-1:0] z_ff, z_in;
   logic signed [W-1:0] hp_ff, hp_in;
   logic signed [W-1:0] c_ff, c_in;
   logic signed [W-1:0] p1_ff, p1_in;
   logic signed [W-1:0] p2_ff, p2_in;
   logic signed [W-1:0] p3_ff, p3_in;
   logic signed [W-1:0] p4_ff, p4_in;
   logic signed [W-1:0] den_ff, den_in;
   logic signed [W-1:0] e_ff, e_in;
   logic signed [W-1:0] k1_ff, k1_in;
   logic signed [W-1:0] k2_ff, k2_in;
   logic signed [W-1:0] omk_ff, omk_in;

   logic                mul_pend_ff, mul_pend_in;
   logic                div_pend_ff, div_pend_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]         rsp_tdata_ff, rsp_tdata_in;

   logic signed [W-1:0] dt_val;
   logic signed [W-1:0] q_val;
   logic signed [W-1:0] r_val;
   logic                csr_write;
   logic                mul_state;
   logic signed [W-1:0] mr;

   avkf_pkg::mul_req_type mul_req;
   avkf_pkg::mul_rsp_type mul_rsp;
   avkf_pkg::div_req_type div_req;
   avkf_pkg::div_rsp_type div_rsp;

   avkf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   avkf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // register values are raw Q16.16 and always fit as positive values
   assign dt_val = W'(step_time_ff);
   assign q_val  = W'(proc_noise_ff);
   assign r_val  = W'(meas_noise_ff);
   assign mr     = mul_rsp.value;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         avkf_pkg::REG_STEP_TIME:         csr_prdata = 32'(step_time_ff);
         avkf_pkg::REG_PROCESS_NOISE:     csr_prdata = 32'(proc_noise_ff);
         avkf_pkg::REG_MEASUREMENT_NOISE: csr_prdata = 32'(meas_noise_ff);
         default:                         csr_prdata = '0;
      endcase
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_state = 1'b1;
      mul_req.a = '0;
      mul_req.b = '0;
      case (state_ff)
         ST_M_VDT: begin
            mul_req.a = v_ff;
            mul_req.b = dt_val;
         end
         ST_M_HVDT: begin
            mul_req.a = phv_ff;
            mul_req.b = dt_val;
         end
         ST_M_VHDT: begin
            mul_req.a = pvh_ff;
            mul_req.b = dt_val;
         end
         ST_M_VVDT: begin
            mul_req.a = pvv_ff;
            mul_req.b = dt_val;
         end
         ST_M_CDT: begin
            mul_req.a = c_ff;
            mul_req.b = dt_val;
         end
         ST_M_K1E: begin
            mul_req.a = k1_ff;
            mul_req.b = e_ff;
         end
         ST_M_K2E: begin
            mul_req.a = k2_ff;
            mul_req.b = e_ff;
         end
         ST_M_P1OMK: begin
            mul_req.a = p1_ff;
            mul_req.b = omk_ff;
         end
         ST_M_P2OMK: begin
            mul_req.a = p2_ff;
            mul_req.b = omk_ff;
         end
         ST_M_K2P1: begin
            mul_req.a = k2_ff;
            mul_req.b = p1_ff;
         end
         ST_M_K2P2: begin
            mul_req.a = k2_ff;
            mul_req.b = p2_ff;
         end
         default: begin
            mul_state = 1'b0;
         end
      endcase
      mul_req.start = mul_state & ~mul_pend_ff;

      div_req.start = (state_ff == ST_DIV) & ~div_pend_ff;
      div_req.num_a = p1_ff;
      div_req.num_b = p2_ff;
      div_req.den   = den_ff;
   end

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      step_time_in  = step_time_ff;
      proc_noise_in = proc_noise_ff;
      meas_noise_in = meas_noise_ff;
      h_in          = h_ff;
      v_in          = v_ff;
      phh_in        = phh_ff;
      phv_in        = phv_ff;
      pvh_in        = pvh_ff;
      pvv_in        = pvv_ff;
      z_in          = z_ff;
      hp_in         = hp_ff;
      c_in          = c_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      p3_in         = p3_ff;
      p4_in         = p4_ff;
      den_in        = den_ff;
      e_in          = e_ff;
      k1_in         = k1_ff;
      k2_in         = k2_ff;
      omk_in        = omk_ff;
      mul_pend_in   = mul_pend_ff;
      div_pend_in   = div_pend_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      if (csr_write) begin
         case (csr_paddr[3:2])
            avkf_pkg::REG_STEP_TIME:
               step_time_in  = csr_pwdata[avkf_pkg::STEP_TIME_W-1:0];
            avkf_pkg::REG_PROCESS_NOISE:
               proc_noise_in = csr_pwdata[avkf_pkg::NOISE_W-1:0];
            avkf_pkg::REG_MEASUREMENT_NOISE:
               meas_noise_in = csr_pwdata[avkf_pkg::NOISE_W-1:0];
            default: ;
         endcase
      end

      if (mul_req.start) mul_pend_in = 1'b1;
      if (mul_rsp.done)  mul_pend_in = 1'b0;
      if (div_req.start) div_pend_in = 1'b1;
      if (div_rsp.done)  div_pend_in = 1'b0;

      // drop the waiting result once it is taken
      if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               z_in     = req_tdata;
               state_in = ST_M_VDT;
            end
         end
         // prediction
         ST_M_VDT: begin
            if (mul_rsp.done) begin
               hp_in    = avkf_pkg::sat_add(h_ff, mr);
               state_in = ST_M_HVDT;
            end
         end
         ST_M_HVDT: begin
            if (mul_rsp.done) begin
               p1_in    = avkf_pkg::sat_add(phh_ff, mr);
               state_in = ST_M_VHDT;
            end
         end
         ST_M_VHDT: begin
            if (mul_rsp.done) begin
               p1_in    = avkf_pkg::sat_add(p1_ff, mr);
               state_in = ST_M_VVDT;
            end
         end
         ST_M_VVDT: begin
            if (mul_rsp.done) begin
               c_in     = mr;
               p2_in    = avkf_pkg::sat_add(phv_ff, mr);
               p3_in    = avkf_pkg::sat_add(pvh_ff, mr);
               p4_in    = avkf_pkg::sat_add(pvv_ff, q_val);
               state_in = ST_M_CDT;
            end
         end
         ST_M_CDT: begin
            if (mul_rsp.done) begin
               p1_in    = avkf_pkg::sat_add(p1_ff, mr);
               state_in = ST_DEN;
            end
         end
         // innovation and gain denominator
         ST_DEN: begin
            den_in   = avkf_pkg::sat_add(p1_ff, r_val);
            e_in     = avkf_pkg::sat_sub(z_ff, hp_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               k1_in    = div_rsp.quo_a;
               k2_in    = div_rsp.quo_b;
               omk_in   = avkf_pkg::sat_sub(avkf_pkg::FIX_ONE, div_rsp.quo_a);
               state_in = ST_M_K1E;
            end
         end
         // correction
         ST_M_K1E: begin
            if (mul_rsp.done) begin
               h_in     = avkf_pkg::sat_add(hp_ff, mr);
               state_in = ST_M_K2E;
            end
         end
         ST_M_K2E: begin
            if (mul_rsp.done) begin
               v_in     = avkf_pkg::sat_add(v_ff, mr);
               state_in = ST_M_P1OMK;
            end
         end
         ST_M_P1OMK: begin
            if (mul_rsp.done) begin
               phh_in   = mr;
               state_in = ST_M_P2OMK;
            end
         end
         ST_M_P2OMK: begin
            if (mul_rsp.done) begin
               phv_in   = mr;
               state_in = ST_M_K2P1;
            end
         end
         ST_M_K2P1: begin
            if (mul_rsp.done) begin
               pvh_in   = avkf_pkg::sat_sub(p3_ff, mr);
               state_in = ST_M_K2P2;
            end
         end
         ST_M_K2P2: begin
            if (mul_rsp.done) begin
               pvv_in   = avkf_pkg::sat_sub(p4_ff, mr);
               state_in = ST_OUT;
            end
         end
         // hold until the output register is free
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {v_ff, h_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_time_ff  <= avkf_pkg::STEP_TIME_RESET;
         proc_noise_ff <= avkf_pkg::PROCESS_NOISE_RESET;
         meas_noise_ff <= avkf_pkg::MEASUREMENT_NOISE_RESET;
         h_ff          <= '0;
         v_ff          <= '0;
         phh_ff        <= avkf_pkg::FIX_ONE;
         phv_ff        <= '0;
         pvh_ff        <= '0;
         pvv_ff        <= avkf_pkg::FIX_ONE;
         mul_pend_ff   <= 1'b0;
         div_pend_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_time_ff  <= step_time_in;
         proc_noise_ff <= proc_noise_in;
         meas_noise_ff <= meas_noise_in;
         h_ff          <= h_in;
         v_ff          <= v_in;
         phh_ff        <= phh_in;
         phv_ff        <= phv_in;
         pvh_ff        <= pvh_in;
         pvv_ff        <= pvv_in;
         mul_pend_ff   <= mul_pend_in;
         div_pend_ff   <= div_pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      z_ff         <= z_in;
      hp_ff        <= hp_in;
      c_ff         <= c_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      p3_ff        <= p3_in;
      p4_ff        <= p4_in;
      den_ff       <= den_in;
      e_ff         <= e_in;
      k1_ff        <= k1_in;
      k2_ff        <= k2_in;
      omk_ff       <= omk_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> mul_pend_ff)
      else $error("multiplier finished with no multiply outstanding");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> div_pend_ff)
      else $error("divider finished with no division outstanding");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_pend_ff && div_pend_ff))
      else $error("multiplier and divider busy at the same time");

   a_result_after_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result presented outside the output step");
`endif

endmodule
